[hw/rtl/sssp_pkg.sv]
`timescale 1ns / 1ps

package sssp_pkg;

  // Defaults for the top-level sizing parameters
  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_MAX_EDGES = 1024;

  // Fixed field widths
  localparam int NODE_FW   = 6;
  localparam int CNT_FW    = 7;
  localparam int WEIGHT_W  = 16;
  localparam int DIST_W    = 31;
  localparam int EDGE_W    = 2 * NODE_FW + WEIGHT_W;
  localparam int EADDR_MAX_W = 16;

  // Stream beat widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Configuration port
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 1'b1;

  // Request kinds carried on tuser
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_RUN = 1'b1;

  localparam logic [DIST_W-1:0] UNREACHED = 31'h7FFF_FFFF;

  // Controller to datapath
  typedef struct packed {
    logic                   edge_we;
    logic                   edge_re;
    logic [EADDR_MAX_W-1:0] edge_addr;
    logic                   dist_init;
    logic                   init_zero;
    logic [NODE_FW-1:0]     node;
    logic                   relax_rd;
    logic                   relax_wr;
    logic                   emit_rd;
    logic                   out_load;
    logic                   last;
    logic [CNT_FW-1:0]      cnt;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic improve;
    logic out_busy;
  } dp_sts_t;

endpackage

[hw/rtl/single_source_shortest_path.sv]
// Add beat: the block is ready again on the next cycle.
// Run beat: seed the distance store with one entry per node (N = clamped node
// count), then sweep over the edge store, at most N sweeps, reading and then writing
// back the distances for each edge; then emit one result per node.
// Reset (rst, synchronous, active high): node_count 1, source_node 0, edge store
// empty, output beat dropped; store contents are not cleared.
`timescale 1ns / 1ps

module single_source_shortest_path #(
  parameter int MAX_NODES = sssp_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = sssp_pkg::DEF_MAX_EDGES
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration writes: index 0 node_count, index 1 source_node
  input  logic                              cfg_we,
  input  logic [sssp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sssp_pkg::CFG_W-1:0]        cfg_data,
  // Request beats
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [5:0] edge_from, [11:6] edge_to, [27:12] edge_weight, [31:28] zero
  input  logic [sssp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [0] req_type: 0 add edge, 1 run search
  input  logic                              s_axis_tuser,
  // Result beats
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [5:0] node_index, [36:6] distance, [39:37] zero
  output logic [sssp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tlast
);
  import sssp_pkg::*;

  // Command and status between the sequencer and the store/relax datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: config registers, edge count, sweep and pass counters
  sssp_ctrl #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd           (cmd),
    .sts           (sts)
  );

  // Datapath: edge store, distance store, relax add/compare, output register.
  // The output register lets the next request beat in while a result waits.
  sssp_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[hw/rtl/sssp_datapath.sv]
`timescale 1ns / 1ps

module sssp_datapath #(
  parameter int MAX_NODES = sssp_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = sssp_pkg::DEF_MAX_EDGES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  sssp_pkg::dp_cmd_t                  cmd,
  output sssp_pkg::dp_sts_t                  sts,
  input  logic [sssp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [sssp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast
);
  import sssp_pkg::*;

  localparam int DADDR_W = $clog2(MAX_NODES);
  localparam int EIDX_W  = $clog2(MAX_EDGES);

  logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
  logic [EDGE_W-1:0] edge_q;
  logic [DIST_W-1:0] dist_mem [MAX_NODES];
  logic [DIST_W-1:0] dist_a;
  logic [DIST_W-1:0] dist_b;

  logic [NODE_FW-1:0]  cur_to;
  logic [WEIGHT_W-1:0] cur_w;
  logic                cur_ok;

  logic               out_valid;
  logic [NODE_FW-1:0] out_node;
  logic [DIST_W-1:0]  out_dist;
  logic               out_last;

  logic [NODE_FW-1:0]  e_from;
  logic [NODE_FW-1:0]  e_to;
  logic [WEIGHT_W-1:0] e_w;
  logic [DADDR_W-1:0]  addr_a;
  logic [DIST_W:0]     cand;
  logic                improve;

  assign e_from = edge_q[NODE_FW-1:0];
  assign e_to   = edge_q[2*NODE_FW-1:NODE_FW];
  assign e_w    = edge_q[EDGE_W-1:2*NODE_FW];
  assign addr_a = cmd.relax_rd ? e_from[DADDR_W-1:0] : cmd.node[DADDR_W-1:0];

  // Edge store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.edge_we) begin
      edge_mem[cmd.edge_addr[EIDX_W-1:0]] <= s_axis_tdata[EDGE_W-1:0];
    end
    if (cmd.edge_re) begin
      edge_q <= edge_mem[cmd.edge_addr[EIDX_W-1:0]];
    end
  end

  assign cand    = {1'b0, dist_a} + {{(DIST_W + 1 - WEIGHT_W){1'b0}}, cur_w};
  assign improve = cur_ok && (dist_a != UNREACHED) && (cand < {1'b0, dist_b});

  // Distance store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.dist_init) begin
      dist_mem[cmd.node[DADDR_W-1:0]] <= cmd.init_zero ? '0 : UNREACHED;
    end else if (cmd.relax_wr && improve) begin
      dist_mem[cur_to[DADDR_W-1:0]] <= cand[DIST_W-1:0];
    end
    if (cmd.relax_rd || cmd.emit_rd) begin
      dist_a <= dist_mem[addr_a];
    end
    if (cmd.relax_rd) begin
      dist_b <= dist_mem[e_to[DADDR_W-1:0]];
      cur_to <= e_to;
      cur_w  <= e_w;
      cur_ok <= ({1'b0, e_from} < cmd.cnt) && ({1'b0, e_to} < cmd.cnt);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_node <= cmd.node;
      out_dist <= dist_a;
      out_last <= cmd.last;
    end
  end

  assign sts.improve  = improve;
  assign sts.out_busy = out_valid && !m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {{(OUT_TDATA_W - DIST_W - NODE_FW){1'b0}}, out_dist, out_node};

endmodule

[hw/rtl/sssp_ctrl.sv]
`timescale 1ns / 1ps

module sssp_ctrl #(
  parameter int MAX_NODES = sssp_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = sssp_pkg::DEF_MAX_EDGES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sssp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sssp_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sssp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             s_axis_tuser,
  output sssp_pkg::dp_cmd_t                cmd,
  input  sssp_pkg::dp_sts_t                sts
);
  import sssp_pkg::*;

  localparam int EIDX_W = $clog2(MAX_EDGES);
  localparam int ETOT_W = $clog2(MAX_EDGES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SW_RD,
    ST_SW_RX,
    ST_EM_RD,
    ST_EM_LD
  } state_t;

  state_t             state, state_next;
  logic [CNT_FW-1:0]  node_count;
  logic [NODE_FW-1:0] source_node;
  logic [ETOT_W-1:0]  edge_total, edge_total_next;
  logic [EIDX_W-1:0]  eidx, eidx_next;
  logic [CNT_FW-1:0]  pass, pass_next;
  logic [NODE_FW-1:0] node, node_next;
  logic               changed, changed_next;

  logic [CNT_FW-1:0]  cnt;
  logic               accept;
  logic               last_edge;
  logic               last_node;
  logic               changed_any;
  logic [NODE_FW-1:0] in_from;
  logic [NODE_FW-1:0] in_to;

  // Clamp the node count into 1..MAX_NODES
  always_comb begin
    if (node_count == '0) begin
      cnt = CNT_FW'(1);
    end else if (node_count > CNT_FW'(MAX_NODES)) begin
      cnt = CNT_FW'(MAX_NODES);
    end else begin
      cnt = node_count;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_from       = s_axis_tdata[NODE_FW-1:0];
  assign in_to         = s_axis_tdata[2*NODE_FW-1:NODE_FW];
  assign last_edge     = (ETOT_W'(eidx) == edge_total - ETOT_W'(1));
  assign last_node     = ({1'b0, node} == cnt - CNT_FW'(1));
  assign changed_any   = changed || sts.improve;

  always_comb begin
    state_next      = state;
    edge_total_next = edge_total;
    eidx_next       = eidx;
    pass_next       = pass;
    node_next       = node;
    changed_next    = changed;
    cmd             = '0;
    cmd.node        = node;
    cmd.cnt         = cnt;
    cmd.init_zero   = (node == source_node);
    cmd.last        = last_node;

    case (state)
      ST_IDLE: begin
        cmd.edge_addr = EADDR_MAX_W'(edge_total[EIDX_W-1:0]);
        if (accept) begin
          if (s_axis_tuser == REQ_RUN) begin
            node_next  = '0;
            state_next = ST_INIT;
          end else if (in_from != in_to && edge_total < ETOT_W'(MAX_EDGES)) begin
            cmd.edge_we     = 1'b1;
            edge_total_next = edge_total + ETOT_W'(1);
          end
        end
      end
      ST_INIT: begin
        cmd.dist_init = 1'b1;
        if (last_node) begin
          cmd.edge_re   = 1'b1;
          cmd.edge_addr = '0;
          eidx_next     = '0;
          pass_next     = '0;
          changed_next  = 1'b0;
          node_next     = '0;
          if (edge_total == '0 || {1'b0, source_node} >= cnt) begin
            edge_total_next = '0;
            state_next      = ST_EM_RD;
          end else begin
            state_next = ST_SW_RD;
          end
        end else begin
          node_next = node + NODE_FW'(1);
        end
      end
      ST_SW_RD: begin
        cmd.relax_rd  = 1'b1;
        cmd.edge_re   = 1'b1;
        cmd.edge_addr = last_edge ? '0 : EADDR_MAX_W'(eidx + EIDX_W'(1));
        state_next    = ST_SW_RX;
      end
      ST_SW_RX: begin
        cmd.relax_wr = 1'b1;
        state_next   = ST_SW_RD;
        if (last_edge) begin
          eidx_next    = '0;
          changed_next = 1'b0;
          if (changed_any && (pass + CNT_FW'(1)) < cnt) begin
            pass_next = pass + CNT_FW'(1);
          end else begin
            edge_total_next = '0;
            node_next       = '0;
            state_next      = ST_EM_RD;
          end
        end else begin
          eidx_next    = eidx + EIDX_W'(1);
          changed_next = changed_any;
        end
      end
      ST_EM_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = ST_EM_LD;
      end
      ST_EM_LD: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          if (last_node) begin
            state_next = ST_IDLE;
          end else begin
            node_next  = node + NODE_FW'(1);
            state_next = ST_EM_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      node_count  <= CNT_FW'(1);
      source_node <= '0;
      edge_total  <= '0;
      eidx        <= '0;
      pass        <= '0;
      node        <= '0;
      changed     <= 1'b0;
    end else begin
      state      <= state_next;
      edge_total <= edge_total_next;
      eidx       <= eidx_next;
      pass       <= pass_next;
      node       <= node_next;
      changed    <= changed_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_NODE_COUNT:  node_count  <= cfg_data;
          REG_SOURCE_NODE: source_node <= cfg_data[NODE_FW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[hw/rtl/sssp_chk.sv]
`timescale 1ns / 1ps

module sssp_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [sssp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);
  import sssp_pkg::*;

  // A stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // Reset drops any pending result
  a_rst_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat survived reset");

  // A run request blocks further requests while it is processed
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_RUN) |=> !s_axis_tready)
    else $error("request taken during a run");

  // Padding bits of the result beat stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:DIST_W+NODE_FW] == '0)
    else $error("result padding not zero");

endmodule

bind single_source_shortest_path sssp_chk u_sssp_chk (.*);

[sim/single_source_shortest_path_test.sv]
`timescale 1ns / 1ps

module single_source_shortest_path_test;
  import sssp_pkg::*;

  localparam int          NODES_MAX   = DEF_MAX_NODES;
  localparam int          ARCS_MAX    = DEF_MAX_EDGES;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          SETTLE      = 8;
  localparam int          TAIL_WAIT   = 64;
  localparam int          REPORT_CAP  = 40;

  // One stored arc of the graph, as the block keeps it
  typedef struct packed {
    logic [NODE_FW-1:0]  tail;
    logic [NODE_FW-1:0]  head;
    logic [WEIGHT_W-1:0] len;
  } arc_t;

  // One distance beat as it should leave the block
  typedef struct {
    logic [NODE_FW-1:0] node;
    logic [DIST_W-1:0]  dist_val;
    logic               last;
  } dist_beat_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // [5:0] edge_from, [11:6] edge_to, [27:12] edge_weight, [31:28] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // [0] req_type
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [5:0] node_index, [36:6] distance, [39:37] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  // Shadow of the block: stored arcs and register copies
  arc_t        arcs [ARCS_MAX];
  int unsigned arcs_held;
  logic [6:0]  nodes_reg;
  logic [5:0]  source_reg;

  dist_beat_t  expected_dist [$];
  dist_beat_t  want;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned beats_sent;
  int unsigned sink_hold;
  bit          no_idle;

  single_source_shortest_path u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Guard against a hung block: give up well past the slowest correct run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Clamp the node count register to the range the search actually uses
  function automatic int unsigned nodes_used();
    if (nodes_reg == 0) return 1;
    if (nodes_reg > NODES_MAX) return NODES_MAX;
    return nodes_reg;
  endfunction

  // Keep an arc unless it loops on itself or the store is already full
  function automatic void store_arc(logic [5:0] tail, logic [5:0] head, logic [15:0] len);
    if (tail != head && arcs_held < ARCS_MAX) begin
      arcs[arcs_held] = '{tail: tail, head: head, len: len};
      arcs_held++;
    end
  endfunction

  // Relax every stored arc in sweeps until nothing improves or the sweep count
  // reaches the node count, queue one distance beat per node, then empty the store
  function automatic void relax_all_arcs();
    int unsigned n;
    int unsigned sweep;
    int unsigned i;
    int unsigned a;
    int unsigned b;
    logic [31:0] best [NODES_MAX];
    logic [31:0] cand;
    logic        moved;
    dist_beat_t  beat;
    n = nodes_used();
    for (i = 0; i < NODES_MAX; i++) best[i] = {1'b0, UNREACHED};
    if (source_reg < n) begin
      best[source_reg] = 0;
      for (sweep = 0; sweep < n; sweep++) begin
        moved = 1'b0;
        for (i = 0; i < arcs_held; i++) begin
          a = arcs[i].tail;
          b = arcs[i].head;
          if (a < n && b < n && best[a] != {1'b0, UNREACHED}) begin
            cand = best[a] + arcs[i].len;
            if (cand < best[b]) begin
              best[b] = cand;
              moved = 1'b1;
            end
          end
        end
        if (!moved) break;
      end
    end
    for (i = 0; i < n; i++) begin
      beat.node     = i[NODE_FW-1:0];
      beat.dist_val = best[i][DIST_W-1:0];
      beat.last     = (i + 1 == n);
      expected_dist.push_back(beat);
    end
    arcs_held = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Print one line per mismatch (up to a cap) and count every one
  task automatic report_mismatch(input string what);
    if (mismatches < REPORT_CAP) $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Compare each accepted result beat, field by field, with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_dist.size() == 0) begin
        report_mismatch($sformatf("unexpected beat node %0d dist %0d",
                                  m_axis_tdata[5:0], m_axis_tdata[36:6]));
      end else begin
        want = expected_dist.pop_front();
        if (m_axis_tdata[5:0] != want.node)
          report_mismatch($sformatf("node_index %0d, want %0d",
                                    m_axis_tdata[5:0], want.node));
        if (m_axis_tdata[36:6] != want.dist_val)
          report_mismatch($sformatf("node %0d distance %0d, want %0d",
                                    want.node, m_axis_tdata[36:6], want.dist_val));
        if (m_axis_tlast != want.last)
          report_mismatch($sformatf("node %0d last %0b, want %0b",
                                    want.node, m_axis_tlast, want.last));
      end
    end
  end

  // Drop tready in random bursts; hold it high during reset and the calm tail
  always @(negedge clk) begin
    if (rst || no_idle) begin
      sink_hold = 0;
      m_axis_tready <= 1'b1;
    end else if (sink_hold != 0) begin
      sink_hold--;
    end else begin
      sink_hold = $urandom_range(1, 16);
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Driving: every task starts and ends just after a falling edge
  // ---------------------------------------------------------------------------

  // Offer one request beat, wait for the handshake, then update the shadow
  task automatic send_beat(input logic req, input logic [5:0] tail, input logic [5:0] head,
                           input logic [15:0] len);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {4'b0, len, head, tail};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    if (req == REQ_RUN) relax_all_arcs();
    else store_arc(tail, head, len);
    if (req == REQ_RUN || tail != head) beats_sent++;
    @(negedge clk);
  endtask

  task automatic add_arc(input logic [5:0] tail, input logic [5:0] head, input logic [15:0] len);
    send_beat(REQ_ADD, tail, head, len);
  endtask

  // Run beat: the arc fields are don't-care, so fill them with noise
  task automatic request_run();
    send_beat(REQ_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
  endtask

  // Hold off until every expected beat is out, plus a margin for a trailing add
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_dist.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NODE_COUNT) nodes_reg = val;
    else source_reg = val[5:0];
  endtask

  task automatic set_graph(input logic [6:0] count, input logic [5:0] src);
    write_reg(REG_NODE_COUNT, count);
    write_reg(REG_SOURCE_NODE, {1'b0, src});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset leaves one node with itself as source and an empty store
  task automatic test_after_reset();
    request_run();
  endtask

  // Shorter path via an extra hop, a self-loop, arcs leaving the graph,
  // an unreachable node and the weight extremes
  task automatic test_small_graph();
    set_graph(7'd6, 6'd0);
    add_arc(6'd0, 6'd1, 16'd5);
    add_arc(6'd1, 6'd2, 16'd3);
    add_arc(6'd0, 6'd2, 16'd10);
    add_arc(6'd3, 6'd3, 16'd0);
    add_arc(6'd2, 6'd63, 16'd1);
    add_arc(6'd63, 6'd4, 16'd0);
    add_arc(6'd2, 6'd4, 16'hFFFF);
    add_arc(6'd4, 6'd0, 16'd0);
    send_beat(REQ_RUN, 6'h3F, 6'h3F, 16'hFFFF);
  endtask

  // Node count zero behaves as one, anything above the maximum as the maximum
  task automatic test_count_clamps();
    set_graph(7'd0, 6'd0);
    add_arc(6'd0, 6'd1, 16'd7);
    request_run();
    set_graph(7'd127, 6'd63);
    add_arc(6'd63, 6'd0, 16'hFFFF);
    add_arc(6'd0, 6'd32, 16'hFFFF);
    add_arc(6'd32, 6'd63, 16'd0);
    request_run();
  endtask

  // A source past the node count leaves every node unreachable
  task automatic test_source_outside();
    set_graph(7'd5, 6'd40);
    add_arc(6'd40, 6'd1, 16'd1);
    add_arc(6'd0, 6'd1, 16'd2);
    request_run();
  endtask

  // A chain stored back to front needs one sweep per hop
  task automatic test_reverse_chain();
    int i;
    set_graph(7'd8, 6'd0);
    for (i = 6; i >= 0; i--) add_arc(i[5:0], i[5:0] + 6'd1, 16'd1 << i);
    request_run();
  endtask

  // Fill the store, then offer arcs that would shorten paths: they must be dropped
  task automatic test_store_full();
    int unsigned k;
    logic [5:0]  tail;
    logic [5:0]  head;
    set_graph(7'd8, 6'd0);
    k = 0;
    while (k < ARCS_MAX) begin
      tail = 6'($urandom_range(0, 63));
      head = 6'($urandom_range(0, 63));
      if (tail != head) begin
        add_arc(tail, head, 16'($urandom));
        k++;
      end
    end
    for (k = 1; k <= 4; k++) add_arc(6'd0, k[5:0], 16'd0);
    request_run();
  endtask

  // Random graphs: mostly arcs inside the graph, with some self-loops, arcs
  // leaving the graph, empty runs and every kind of node count and source
  task automatic test_random_graphs(input int unsigned target);
    int unsigned n;
    int unsigned adds;
    int unsigned k;
    logic [6:0]  count;
    logic [5:0]  src;
    logic [5:0]  tail;
    logic [5:0]  head;
    logic [15:0] len;
    while (beats_sent < target) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       count = 7'd0;
          1:       count = 7'($urandom_range(65, 127));
          2:       count = 7'd64;
          3:       count = 7'd1;
          default: count = 7'($urandom_range(2, 16));
        endcase
        n = (count == 0) ? 1 : (count > NODES_MAX ? NODES_MAX : count);
        if ($urandom_range(0, 4) == 0) src = 6'($urandom_range(0, 63));
        else src = 6'($urandom_range(0, n - 1));
        set_graph(count, src);
      end
      n = nodes_used();
      adds = $urandom_range(0, 12);
      for (k = 0; k < adds; k++) begin
        if ($urandom_range(0, 6) == 0) begin
          tail = 6'($urandom_range(0, 63));
          head = 6'($urandom_range(0, 63));
        end else begin
          tail = 6'($urandom_range(0, n - 1));
          head = 6'($urandom_range(0, n - 1));
        end
        if ($urandom_range(0, 19) == 0) head = tail;
        case ($urandom_range(0, 7))
          0:       len = 16'd0;
          1:       len = 16'hFFFF;
          2, 3:    len = 16'($urandom_range(0, 15));
          default: len = 16'($urandom);
        endcase
        add_arc(tail, head, len);
      end
      request_run();
    end
  endtask

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b1;
    nodes_reg     = 7'd1;
    source_reg    = 6'd0;
    arcs_held     = 0;
    mismatches    = 0;
    cycle_count   = 0;
    beats_sent    = 0;
    sink_hold     = 0;
    no_idle       = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_after_reset();
    test_small_graph();
    test_count_clamps();
    test_source_outside();
    test_reverse_chain();
    test_store_full();
    beats_sent = 0;
    test_random_graphs(120);
    // Calm tail: no idling on either side
    wait_idle();
    no_idle = 1'b1;
    test_random_graphs(145);

    wait_idle();
    repeat (TAIL_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
